>>> rtl/window_sum_threshold_scorer_core_macros.svh
// Assertion macros for the windowed-sum scorer.
// Used by the top level. Expects signals named clk and rst in scope.
`ifndef WINDOW_SUM_THRESHOLD_SCORER_CORE_MACROS_SVH
`define WINDOW_SUM_THRESHOLD_SCORER_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define WSTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scorer check failed");

// Next-cycle implication, off during reset.
`define WSTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scorer check failed");

`endif

>>> rtl/wsts_pkg.sv
// Shared types and constants for the windowed-sum scorer.
// No dependencies.
package wsts_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WL_W        = 7;   // window length register
  localparam int THR_W       = 23;  // threshold registers
  localparam int SCORE_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 23;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_UPPER_THRESHOLD = 2'd1,
    CFG_LOWER_THRESHOLD = 2'd2
  } cfg_index_t;

  // Control from the top level to the update stage.
  typedef struct packed {
    logic advance;   // word moves from input register to result register
    logic last;      // that word closes the sequence
    logic restart;   // window length written: clear sequence state
  } step_ctl_t;

  // Status back from the update stage.
  typedef struct packed {
    logic seq_clear;      // sum, fill, pointer and score all zero
    logic fill_in_range;  // fill count within the delay line depth
  } step_stat_t;

endpackage

>>> rtl/wsts_if.sv
// Valid/ready channel interfaces for samples in and scores out.
// Depends on wsts_pkg for widths.
interface wsts_in_if #(
  parameter int SAMPLE_BITS = wsts_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wsts_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wsts_pkg::SCORE_W-1:0]   score;
  logic                                  final_res;

  modport source (output valid, output score, output final_res, input ready);
  modport sink   (input valid, input score, input final_res, output ready);
endinterface

>>> rtl/wsts_delay.sv
// Sample delay line: one write port, one prefetching read port with bypass.
// Depends on wsts_pkg only through parameters handed down.
module wsts_delay #(
  parameter int MAX_WINDOW  = wsts_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wsts_pkg::SAMPLE_BITS_DEF,
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic signed [SAMPLE_BITS-1:0] rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Fetch the sample that leaves the window on the next word; forward a
  // same-cycle write so a window of one sees the sample just stored.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/wsts_stage.sv
// Sequence state and its registered update: moving sum, fill count, pointer, score.
// Depends on wsts_pkg for control types and score limits.
module wsts_stage #(
  parameter int MAX_WINDOW  = wsts_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wsts_pkg::SAMPLE_BITS_DEF,
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int LEN_W = $clog2(MAX_WINDOW + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wsts_pkg::step_ctl_t                  ctl,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [LEN_W-1:0]                     len,
  input  logic [LEN_W-1:0]                     len_next,
  input  logic signed [wsts_pkg::THR_W-1:0]    upper,
  input  logic signed [wsts_pkg::THR_W-1:0]    lower,
  input  logic signed [SAMPLE_BITS-1:0]        old,
  output logic                                 mem_we,
  output logic [AW-1:0]                        mem_waddr,
  output logic [AW-1:0]                        mem_raddr,
  output logic signed [wsts_pkg::SCORE_W-1:0]  score_new,
  output wsts_pkg::step_stat_t                 stat
);

  localparam int SUM_W = SAMPLE_BITS + AW;
  localparam int CMP_W = (SUM_W > wsts_pkg::THR_W) ? SUM_W : wsts_pkg::THR_W;
  localparam int SCORE_W = wsts_pkg::SCORE_W;

  logic [AW-1:0]               wp, wp_next, wp_inc;
  logic [LEN_W-1:0]            fill, fill_next, fill_inc;
  logic signed [SUM_W-1:0]     sum, sum_next, sum_new;
  logic signed [SCORE_W-1:0]   score, score_next;
  logic signed [SAMPLE_BITS-1:0] old_eff;
  logic signed [CMP_W-1:0]     sum_cmp, upper_cmp, lower_cmp;
  logic                        window_full;
  logic [LEN_W:0]              wp_x, len_x, raddr_x;

  assign wp_inc   = (wp == AW'(MAX_WINDOW - 1)) ? '0 : wp + AW'(1);
  assign fill_inc = (fill == LEN_W'(MAX_WINDOW)) ? fill : fill + LEN_W'(1);
  assign old_eff  = (fill >= len) ? old : '0;
  assign sum_new  = sum + SUM_W'(sample) - SUM_W'(old_eff);

  assign window_full = fill_inc >= len;
  assign sum_cmp     = CMP_W'(sum_new);
  assign upper_cmp   = CMP_W'(upper);
  assign lower_cmp   = CMP_W'(lower);

  always_comb begin
    score_new = score;
    if (window_full) begin
      if (sum_cmp > upper_cmp) begin
        if (score != wsts_pkg::SCORE_MAX) score_new = score + SCORE_W'(1);
      end else if (sum_cmp < lower_cmp) begin
        if (score != wsts_pkg::SCORE_MIN) score_new = score - SCORE_W'(1);
      end
    end
  end

  always_comb begin
    wp_next    = wp;
    fill_next  = fill;
    sum_next   = sum;
    score_next = score;
    if (ctl.restart || (ctl.advance && ctl.last)) begin
      wp_next    = '0;
      fill_next  = '0;
      sum_next   = '0;
      score_next = '0;
    end else if (ctl.advance) begin
      wp_next    = wp_inc;
      fill_next  = fill_inc;
      sum_next   = sum_new;
      score_next = score_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      fill  <= '0;
      sum   <= '0;
      score <= '0;
    end else begin
      wp    <= wp_next;
      fill  <= fill_next;
      sum   <= sum_next;
      score <= score_next;
    end
  end

  // Slot that leaves the window for the word after this one.
  assign wp_x    = (LEN_W + 1)'(wp_next);
  assign len_x   = (LEN_W + 1)'(len_next);
  assign raddr_x = (wp_x >= len_x) ? (wp_x - len_x)
                                   : (wp_x + (LEN_W + 1)'(MAX_WINDOW) - len_x);

  assign mem_we    = ctl.advance;
  assign mem_waddr = wp;
  assign mem_raddr = raddr_x[AW-1:0];

  assign stat.seq_clear     = (fill == '0) && (sum == '0) && (score == '0) && (wp == '0);
  assign stat.fill_in_range = fill <= LEN_W'(MAX_WINDOW);

endmodule

>>> rtl/window_sum_threshold_scorer_core.sv
// Windowed-sum threshold scorer, top level: channels, configuration, pipeline.
// Depends on wsts_pkg, wsts_if, wsts_delay, wsts_stage and the macros header.
//
// Takes one signed sample per cycle and returns one score word per sample,
// passed through the input register, then the result register; a new
// sample is accepted in every cycle while the result side keeps taking words.
// The rate is set by the registered update of the moving sum and score,
// with the leaving sample prefetched from the delay-line memory before use.
// A window of w samples scores only once w samples of the current
// sequence are held; the word marked last returns the total and clears the
// sequence. Writing the window length also clears the sequence; thresholds
// apply from the next sample. Write configuration only while idle.
`include "window_sum_threshold_scorer_core_macros.svh"

module window_sum_threshold_scorer_core #(
  parameter int MAX_WINDOW  = wsts_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wsts_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  wsts_in_if.sink                               samples,
  wsts_out_if.source                            results,
  input  logic                                  cfg_we,
  input  logic [wsts_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wsts_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int WL_W   = wsts_pkg::WL_W;
  localparam int LCMP_W = (WL_W > LEN_W) ? WL_W : LEN_W;

  // Configuration
  logic [LEN_W-1:0]                       eff_len, len_calc, len_next;
  logic signed [wsts_pkg::THR_W-1:0]      upper, lower;
  logic [LCMP_W-1:0]                      wl_x;
  logic                                   restart;

  // Pipeline
  logic                                   in_valid_q;
  logic signed [SAMPLE_BITS-1:0]          sample_q;
  logic                                   last_q;
  logic                                   out_valid_q;
  logic signed [wsts_pkg::SCORE_W-1:0]    score_q;
  logic                                   final_q;
  logic                                   advance;

  wsts_pkg::step_ctl_t                    ctl;
  wsts_pkg::step_stat_t                   stat;
  logic                                   mem_we;
  logic [AW-1:0]                          mem_waddr, mem_raddr;
  logic signed [SAMPLE_BITS-1:0]          old;
  logic signed [wsts_pkg::SCORE_W-1:0]    score_new;

  // Clamp the written length to one..MAX_WINDOW.
  assign wl_x = LCMP_W'(cfg_data[WL_W-1:0]);
  always_comb begin
    if (wl_x == '0) begin
      len_calc = LEN_W'(1);
    end else if (wl_x > LCMP_W'(MAX_WINDOW)) begin
      len_calc = LEN_W'(MAX_WINDOW);
    end else begin
      len_calc = wl_x[LEN_W-1:0];
    end
  end

  assign restart  = cfg_we && (cfg_index == wsts_pkg::CFG_WINDOW_LENGTH);
  assign len_next = restart ? len_calc : eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= LEN_W'(1);
      upper   <= '0;
      lower   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wsts_pkg::CFG_WINDOW_LENGTH:   eff_len <= len_calc;
        wsts_pkg::CFG_UPPER_THRESHOLD: upper   <= cfg_data[wsts_pkg::THR_W-1:0];
        wsts_pkg::CFG_LOWER_THRESHOLD: lower   <= cfg_data[wsts_pkg::THR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Advance when the result register is empty or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || results.ready);
  assign samples.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      sample_q <= samples.sample;
      last_q   <= samples.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (results.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      score_q <= score_new;
      final_q <= last_q;
    end
  end

  assign results.valid     = out_valid_q;
  assign results.score     = score_q;
  assign results.final_res = final_q;

  assign ctl.advance = advance;
  assign ctl.last    = last_q;
  assign ctl.restart = restart;

  wsts_delay #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_delay (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (sample_q),
    .raddr (mem_raddr),
    .rdata (old)
  );

  wsts_stage #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_stage (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sample    (sample_q),
    .len       (eff_len),
    .len_next  (len_next),
    .upper     (upper),
    .lower     (lower),
    .old       (old),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .score_new (score_new),
    .stat      (stat)
  );

  `WSTS_ASSERT_NEXT(a_last_clears_seq, advance && last_q, stat.seq_clear)
  `WSTS_ASSERT_NOW(a_fill_bounded, 1'b1, stat.fill_in_range)
  `WSTS_ASSERT_NEXT(a_result_loaded, advance, results.valid && (results.final_res == $past(last_q)))
  `WSTS_ASSERT_NOW(a_no_overwrite, out_valid_q && !results.ready, !advance)

endmodule

>>> dv/tb_window_sum_threshold_scorer_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the windowed-sum threshold scorer core: drives sample words,
// predicts each score word in a small scoreboard class and compares field by field.
// Depends on wsts_pkg, the channel interfaces in wsts_if and the core itself.

module tb_window_sum_threshold_scorer_core;

  localparam int HISTORY_DEPTH     = wsts_pkg::MAX_WINDOW_DEF;
  localparam int ITEM_TARGET       = 1400;
  localparam int MAX_IDLE          = 11;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_LIMIT       = 5000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int THR_MAX           = (1 << (wsts_pkg::THR_W - 1)) - 1;
  localparam int THR_MIN           = -(1 << (wsts_pkg::THR_W - 1));

  localparam logic [wsts_pkg::CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 2'd3;

  typedef logic signed [wsts_pkg::SAMPLE_BITS_DEF-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef struct {
    logic signed [wsts_pkg::SCORE_W-1:0] score;
    logic                                final_res;
  } score_word_t;

  class score_tracker;
    sample_t                             history [HISTORY_DEPTH];
    int unsigned                         wr_ptr;
    int unsigned                         fill;
    int                                  wsum;
    logic signed [wsts_pkg::SCORE_W-1:0] tally;
    logic [wsts_pkg::WL_W-1:0]           win_len;
    int                                  upper_thr;
    int                                  lower_thr;
    score_word_t                         expected_scores [$];
    int                                  errors;
    int                                  compared;
    int                                  sequences;

    function new();
      foreach (history[i]) history[i] = '0;
      win_len   = 7'd1;
      upper_thr = 0;
      lower_thr = 0;
      errors    = 0;
      compared  = 0;
      sequences = 0;
      restart();
    endfunction

    function void restart();
      wr_ptr = 0;
      fill   = 0;
      wsum   = 0;
      tally  = '0;
    endfunction

    // Zero behaves as one, anything past the delay line as its full depth.
    function int unsigned window_span();
      if (win_len == 0) return 1;
      if (win_len > HISTORY_DEPTH) return HISTORY_DEPTH;
      return win_len;
    endfunction

    function void write_reg(logic [wsts_pkg::CFG_INDEX_W-1:0] idx,
                            logic [wsts_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wsts_pkg::CFG_WINDOW_LENGTH: begin
          win_len = data[wsts_pkg::WL_W-1:0];
          restart();
        end
        wsts_pkg::CFG_UPPER_THRESHOLD: upper_thr = $signed(data[wsts_pkg::THR_W-1:0]);
        wsts_pkg::CFG_LOWER_THRESHOLD: lower_thr = $signed(data[wsts_pkg::THR_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s, logic l);
      int unsigned span;
      int          leaving;
      score_word_t w;
      span    = window_span();
      leaving = 0;
      // Take the leaving sample before its slot is overwritten.
      if (fill >= span) leaving = history[(wr_ptr + HISTORY_DEPTH - span) % HISTORY_DEPTH];
      wsum = wsum + s - leaving;
      history[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
      if (fill < HISTORY_DEPTH) fill++;
      if (fill >= span) begin
        if (wsum > upper_thr) begin
          if (tally != wsts_pkg::SCORE_MAX) tally++;
        end else if (wsum < lower_thr) begin
          if (tally != wsts_pkg::SCORE_MIN) tally--;
        end
      end
      w.score     = tally;
      w.final_res = l;
      expected_scores.push_back(w);
      if (l) begin
        restart();
        sequences++;
      end
    endfunction

    function void check_word(logic signed [wsts_pkg::SCORE_W-1:0] score, logic final_res);
      score_word_t w;
      if (expected_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected score word: expected none, actual score %0d final %0b",
                 $time, score, final_res);
        return;
      end
      w = expected_scores.pop_front();
      compared++;
      if (score !== w.score) begin
        errors++;
        $display("%0t: score mismatch: expected %0d, actual %0d", $time, w.score, score);
      end
      if (final_res !== w.final_res) begin
        errors++;
        $display("%0t: final flag mismatch: expected %0b, actual %0b",
                 $time, w.final_res, final_res);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [wsts_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wsts_pkg::CFG_DATA_W-1:0]  cfg_data;

  wsts_in_if #(.SAMPLE_BITS(wsts_pkg::SAMPLE_BITS_DEF)) samples_if ();
  wsts_out_if                                           results_if ();

  score_tracker tracker = new();

  bit src_idle;
  bit sink_idle;
  bit long_stall_req;
  int items_sent;
  int settings_used;

  window_sum_threshold_scorer_core dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1)
      tracker.check_word(results_if.score, results_if.final_res);
  end

  initial begin : result_sink
    int stall;
    results_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_stall_req) begin
        results_if.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall_req = 1'b0;
      end
      stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (results_if.valid !== 1'b1);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("window_sum_threshold_scorer_core test failed");
    $finish;
  end

  task automatic send_word(input sample_t s, input logic l);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= s;
    samples_if.last   <= l;
    do @(posedge clk); while (samples_if.ready !== 1'b1);
    tracker.note_sample(s, l);
    items_sent++;
  endtask

  task automatic program_reg(input logic [wsts_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wsts_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Hold the input until every expected word is back, then let the pipeline settle.
  task automatic drain_results();
    int guard;
    samples_if.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (tracker.expected_scores.size() != 0 && guard < DRAIN_LIMIT);
    if (tracker.expected_scores.size() != 0) begin
      tracker.errors++;
      $display("%0t: missing score words: expected %0d more, actual none",
               $time, tracker.expected_scores.size());
      tracker.expected_scores.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t pick_sample(int bias);
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2:    v = int'($urandom_range(0, 64)) - 32;
      3, 4, 5: begin
        if (bias > 0)      v = int'($urandom_range(0, 32767));
        else if (bias < 0) v = -int'($urandom_range(1, 32768));
        else               v = int'($urandom_range(0, 65535)) - 32768;
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return sample_t'(v);
  endfunction

  // Keep most thresholds inside the reachable sum range so that windows score both ways.
  function automatic int pick_threshold(int unsigned span);
    int reach;
    case ($urandom_range(0, 7))
      0:       return THR_MIN;
      1:       return THR_MAX;
      default: begin
        reach = 16384 * span;
        return int'($urandom_range(0, 2 * reach)) - reach;
      end
    endcase
  endfunction

  initial begin : stimulus
    int                              phase;
    int                              bias;
    int                              n_seq;
    int                              seq_len;
    int unsigned                     span;
    logic [wsts_pkg::WL_W-1:0]       wl;
    logic [wsts_pkg::CFG_DATA_W-1:0] wdata;
    bit                              unfinished;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    samples_if.valid  <= 1'b0;
    samples_if.sample <= '0;
    samples_if.last   <= 1'b0;
    src_idle          = 1'b0;
    sink_idle         = 1'b0;
    long_stall_req    = 1'b0;
    items_sent        = 0;
    settings_used     = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: window of one, both thresholds at zero.
    send_word('0, 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(sample_t'(-1), 1'b0);
    send_word(sample_t'(1), 1'b1);
    drain_results();

    // Write past the register list: must change nothing.
    program_reg(CFG_INDEX_UNUSED, 23'h7FFFFF);
    send_word(sample_t'(2), 1'b1);
    drain_results();

    // Window length zero acts as one.
    program_reg(wsts_pkg::CFG_WINDOW_LENGTH, '0);
    program_reg(wsts_pkg::CFG_UPPER_THRESHOLD, wsts_pkg::CFG_DATA_W'(100));
    program_reg(wsts_pkg::CFG_LOWER_THRESHOLD, wsts_pkg::CFG_DATA_W'(-100));
    settings_used++;
    send_word(sample_t'(100), 1'b0);
    send_word(sample_t'(101), 1'b0);
    send_word(sample_t'(-101), 1'b1);
    drain_results();

    // Oversized window clamps to the full depth; a short sequence never scores.
    program_reg(wsts_pkg::CFG_WINDOW_LENGTH, wsts_pkg::CFG_DATA_W'(100));
    settings_used++;
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, 1'b1);
    drain_results();

    // Thresholds at the far ends: nothing scores.
    program_reg(wsts_pkg::CFG_WINDOW_LENGTH, wsts_pkg::CFG_DATA_W'(3));
    program_reg(wsts_pkg::CFG_UPPER_THRESHOLD, wsts_pkg::CFG_DATA_W'(THR_MAX));
    program_reg(wsts_pkg::CFG_LOWER_THRESHOLD, wsts_pkg::CFG_DATA_W'(THR_MIN));
    settings_used++;
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b1);
    drain_results();

    // Crossed thresholds: upper wins; then move upper mid-sequence, state kept.
    program_reg(wsts_pkg::CFG_UPPER_THRESHOLD, wsts_pkg::CFG_DATA_W'(THR_MIN));
    program_reg(wsts_pkg::CFG_LOWER_THRESHOLD, wsts_pkg::CFG_DATA_W'(THR_MAX));
    settings_used++;
    repeat (4) send_word(SAMPLE_MIN, 1'b0);
    drain_results();
    program_reg(wsts_pkg::CFG_UPPER_THRESHOLD, '0);
    settings_used++;
    send_word(SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MIN, 1'b1);
    drain_results();

    // Window length written mid-sequence restarts it.
    program_reg(wsts_pkg::CFG_WINDOW_LENGTH, wsts_pkg::CFG_DATA_W'(2));
    settings_used++;
    send_word(sample_t'(10), 1'b0);
    send_word(sample_t'(20), 1'b0);
    drain_results();
    program_reg(wsts_pkg::CFG_WINDOW_LENGTH, wsts_pkg::CFG_DATA_W'(2));
    send_word(sample_t'(5), 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       wl = '0;
          1:       wl = wsts_pkg::WL_W'(HISTORY_DEPTH);
          2:       wl = wsts_pkg::WL_W'($urandom_range(HISTORY_DEPTH + 1, 127));
          3, 4:    wl = wsts_pkg::WL_W'($urandom_range(1, HISTORY_DEPTH));
          default: wl = wsts_pkg::WL_W'($urandom_range(1, 8));
        endcase
        wdata = wsts_pkg::CFG_DATA_W'($urandom());
        wdata[wsts_pkg::WL_W-1:0] = wl;
        program_reg(wsts_pkg::CFG_WINDOW_LENGTH, wdata);
      end
      span = tracker.window_span();
      if (phase == 0 || $urandom_range(0, 3) != 0)
        program_reg(wsts_pkg::CFG_UPPER_THRESHOLD,
                    wsts_pkg::CFG_DATA_W'(pick_threshold(span)));
      if (phase == 0 || $urandom_range(0, 3) != 0)
        program_reg(wsts_pkg::CFG_LOWER_THRESHOLD,
                    wsts_pkg::CFG_DATA_W'(pick_threshold(span)));
      if ($urandom_range(0, 7) == 0)
        program_reg(CFG_INDEX_UNUSED, wsts_pkg::CFG_DATA_W'($urandom()));
      settings_used++;
      bias = int'($urandom_range(0, 2)) - 1;

      // Back up the result side while words keep coming, so the input stalls.
      if (phase == 3) begin
        src_idle       = 1'b0;
        long_stall_req = 1'b1;
      end

      n_seq = $urandom_range(1, 3);
      for (int q = 0; q < n_seq; q++) begin
        if ($urandom_range(0, 6) == 0) seq_len = $urandom_range(1, span);
        else                           seq_len = span + $urandom_range(0, 30);
        unfinished = (q == n_seq - 1) && ($urandom_range(0, 4) == 0);
        for (int k = 0; k < seq_len; k++)
          send_word(pick_sample(bias), (k == seq_len - 1) && !unfinished);
      end
      phase++;
    end
    drain_results();

    $display("Sent %0d sample words, %0d closed sequences, %0d register settings;",
             items_sent, tracker.sequences, settings_used);
    $display("compared %0d score words, %0d mismatches.", tracker.compared, tracker.errors);
    if (tracker.errors == 0) begin
      $display("window_sum_threshold_scorer_core test passed");
    end else begin
      $display("window_sum_threshold_scorer_core test failed");
    end
    $finish;
  end

endmodule
